// File: hdl/multi_channel_countdown_timer_bank_defines.svh
// assertion macros shared by the checker
`ifndef MULTI_CHANNEL_COUNTDOWN_TIMER_BANK_DEFINES_SVH
`define MULTI_CHANNEL_COUNTDOWN_TIMER_BANK_DEFINES_SVH

// same-cycle implication
`define MCCT_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("timer bank check failed");

// next-cycle implication
`define MCCT_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("timer bank check failed");

`endif

// File: hdl/mcct_pkg.sv
`timescale 1ns / 1ps

package mcct_pkg;

  localparam int NUM_TIMERS  = 16;
  localparam int COUNT_WIDTH = 32;
  localparam int IDX_W  = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int SLOT_W = $clog2(NUM_TIMERS + 1);

  typedef enum logic [2:0] {
    OP_TICK        = 3'd0,
    OP_ALLOC       = 3'd1,
    OP_SET_PERIOD  = 3'd2,
    OP_STOP        = 3'd3,
    OP_RESTART     = 3'd4,
    OP_POLL        = 3'd5,
    OP_READ_PERIOD = 3'd6,
    OP_READ_COUNT  = 3'd7
  } opcode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMD,
    ST_TICK
  } state_t;

  typedef struct packed {
    opcode_t     opcode;
    logic [3:0]  timer_index;
    logic [31:0] value;
    logic        cycle_mode;
  } cmd_t;

  typedef struct packed {
    logic [31:0] read_value;
    logic        flag_was_set;
    logic [3:0]  assigned_index;
    logic        bank_full;
    logic        expiry_seen;
    logic [3:0]  expired_index;
  } rsp_t;

  typedef struct packed {
    logic                   mode;
    logic [COUNT_WIDTH-1:0] period;
    logic [COUNT_WIDTH-1:0] count;
  } entry_t;

  typedef struct packed {
    entry_t      wr_entry;
    logic        wr_en;
    logic        expired;
    logic        clr_flag;
    logic        flag_was;
    logic [31:0] read_value;
  } alu_out_t;

endpackage

// File: hdl/mcct_ram.sv
`timescale 1ns / 1ps

module mcct_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic                                   rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: hdl/mcct_alu.sv
`timescale 1ns / 1ps

module mcct_alu (
  input  mcct_pkg::opcode_t                  opcode,
  input  logic [mcct_pkg::COUNT_WIDTH-1:0]   value,
  input  mcct_pkg::entry_t                   entry,
  input  logic                               flag,
  output mcct_pkg::alu_out_t                 res
);

  always_comb begin
    res = '0;
    res.wr_entry = entry;
    case (opcode)
      mcct_pkg::OP_TICK: begin
        if (entry.count != '0 && entry.count <= entry.period) begin
          res.wr_en = 1'b1;
          res.wr_entry.count = entry.count - 1'b1;
          if (entry.count == mcct_pkg::COUNT_WIDTH'(1)) begin
            res.expired = 1'b1;
            if (entry.mode) begin
              res.wr_entry.count = entry.period;
            end
          end
        end
      end
      mcct_pkg::OP_SET_PERIOD: begin
        res.wr_en = 1'b1;
        res.wr_entry.period = value;
        res.wr_entry.count = '0;
      end
      mcct_pkg::OP_STOP: begin
        res.wr_en = 1'b1;
        res.wr_entry.count = '0;
      end
      mcct_pkg::OP_RESTART: begin
        res.wr_en = 1'b1;
        res.wr_entry.count = (value != '0) ? value : entry.period;
      end
      mcct_pkg::OP_POLL: begin
        res.flag_was = flag;
        res.clr_flag = 1'b1;
      end
      mcct_pkg::OP_READ_PERIOD: begin
        res.read_value = 32'(entry.period);
      end
      mcct_pkg::OP_READ_COUNT: begin
        res.read_value = 32'(entry.count);
      end
      default: begin
      end
    endcase
  end

endmodule

// File: hdl/multi_channel_countdown_timer_bank.sv
`timescale 1ns / 1ps
// allocate and out-of-range commands: result strobe in the cycle after the item is taken
// other timer commands: one synchronous read of the timer ram, then a write-back for stop, set-period and restart
// tick: the walk reads one allocated timer per cycle; with 0 slots in use done comes without a ram read
// busy stays high while a read of the timer ram is in progress; results go out on done, no stall
// synchronous reset clears slot count, expiry flags and per-entry valid bits

module multi_channel_countdown_timer_bank (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  mcct_pkg::cmd_t  cmd,
  output logic            done,
  output mcct_pkg::rsp_t  result
);

  localparam int IDX_W  = mcct_pkg::IDX_W;
  localparam int SLOT_W = mcct_pkg::SLOT_W;
  localparam int NT     = mcct_pkg::NUM_TIMERS;

  mcct_pkg::state_t state, state_next;
  mcct_pkg::cmd_t   cmd_q, cmd_next;
  mcct_pkg::rsp_t   result_next;
  logic             done_next;
  logic [SLOT_W-1:0] slots, slots_next;
  logic [NT-1:0]     flags, flags_next;
  logic [NT-1:0]     entry_valid, valid_next;
  logic [IDX_W-1:0]  rd_addr_q;
  logic              seen, seen_next;
  logic [IDX_W-1:0]  last_idx, last_next;

  logic              rd_en;
  logic [IDX_W-1:0]  rd_addr;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  mcct_pkg::entry_t  wr_data;
  mcct_pkg::entry_t  ram_q;
  mcct_pkg::entry_t  entry_eff;
  mcct_pkg::alu_out_t alu_res;
  logic [mcct_pkg::COUNT_WIDTH-1:0] in_value;
  logic              index_ok;

  mcct_ram #(
    .WIDTH($bits(mcct_pkg::entry_t)),
    .DEPTH(NT)
  ) u_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(ram_q)
  );

  // never-written entries read as zero
  assign entry_eff = entry_valid[rd_addr_q] ? ram_q : '0;

  mcct_alu u_alu (
    .opcode(cmd_q.opcode),
    .value (mcct_pkg::COUNT_WIDTH'(cmd_q.value)),
    .entry (entry_eff),
    .flag  (flags[rd_addr_q]),
    .res   (alu_res)
  );

  assign in_value = mcct_pkg::COUNT_WIDTH'(cmd.value);
  assign index_ok = ({1'b0, cmd.timer_index} < 5'(NT));
  assign busy     = (state != mcct_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= mcct_pkg::ST_IDLE;
      done        <= 1'b0;
      slots       <= '0;
      flags       <= '0;
      entry_valid <= '0;
      seen        <= 1'b0;
    end else begin
      state       <= state_next;
      done        <= done_next;
      slots       <= slots_next;
      flags       <= flags_next;
      entry_valid <= valid_next;
      seen        <= seen_next;
    end
  end

  always_ff @(posedge clk) begin
    cmd_q    <= cmd_next;
    result   <= result_next;
    last_idx <= last_next;
    if (rd_en) begin
      rd_addr_q <= rd_addr;
    end
  end

  always_comb begin
    state_next  = state;
    cmd_next    = cmd_q;
    result_next = result;
    done_next   = 1'b0;
    slots_next  = slots;
    flags_next  = flags;
    valid_next  = entry_valid;
    seen_next   = seen;
    last_next   = last_idx;
    rd_en       = 1'b0;
    rd_addr     = '0;
    wr_en       = 1'b0;
    wr_addr     = rd_addr_q;
    wr_data     = alu_res.wr_entry;
    case (state)
      mcct_pkg::ST_IDLE: begin
        if (start) begin
          cmd_next    = cmd;
          result_next = '0;
          case (cmd.opcode)
            mcct_pkg::OP_TICK: begin
              if (slots == '0) begin
                done_next = 1'b1;
              end else begin
                rd_en      = 1'b1;
                rd_addr    = '0;
                seen_next  = 1'b0;
                last_next  = '0;
                state_next = mcct_pkg::ST_TICK;
              end
            end
            mcct_pkg::OP_ALLOC: begin
              done_next = 1'b1;
              if (slots >= SLOT_W'(NT)) begin
                result_next.bank_full = 1'b1;
              end else begin
                wr_en        = 1'b1;
                wr_addr      = IDX_W'(slots);
                wr_data.mode   = cmd.cycle_mode;
                wr_data.period = in_value;
                wr_data.count  = in_value;
                valid_next[IDX_W'(slots)] = 1'b1;
                flags_next[IDX_W'(slots)] = 1'b0;
                slots_next   = slots + 1'b1;
                result_next.assigned_index = 4'(slots);
              end
            end
            default: begin
              if (index_ok) begin
                rd_en      = 1'b1;
                rd_addr    = IDX_W'(cmd.timer_index);
                state_next = mcct_pkg::ST_CMD;
              end else begin
                done_next = 1'b1;
              end
            end
          endcase
        end
      end
      mcct_pkg::ST_CMD: begin
        wr_en = alu_res.wr_en;
        if (alu_res.wr_en) begin
          valid_next[rd_addr_q] = 1'b1;
        end
        if (alu_res.clr_flag) begin
          flags_next[rd_addr_q] = 1'b0;
        end
        result_next.read_value   = alu_res.read_value;
        result_next.flag_was_set = alu_res.flag_was;
        done_next  = 1'b1;
        state_next = mcct_pkg::ST_IDLE;
      end
      mcct_pkg::ST_TICK: begin
        wr_en = alu_res.wr_en;
        if (alu_res.expired) begin
          flags_next[rd_addr_q] = 1'b1;
          seen_next = 1'b1;
          last_next = rd_addr_q;
        end
        if ((SLOT_W'(rd_addr_q) + SLOT_W'(1)) < slots) begin
          rd_en   = 1'b1;
          rd_addr = rd_addr_q + 1'b1;
        end else begin
          result_next.expiry_seen   = seen_next;
          result_next.expired_index = 4'(last_next);
          done_next  = 1'b1;
          state_next = mcct_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = mcct_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// File: hdl/mcct_checker.sv
`timescale 1ns / 1ps
`include "multi_channel_countdown_timer_bank_defines.svh"

module mcct_checker (
  input logic           clk,
  input logic           rst,
  input logic           start,
  input logic           busy,
  input logic           done,
  input mcct_pkg::rsp_t result
);

  `MCCT_ASSERT_NXT(a_accept_progress, clk, rst, start && !busy, busy || done)
  `MCCT_ASSERT_NXT(a_no_spurious_busy, clk, rst, !busy && !start, !busy)
  `MCCT_ASSERT_IMP(a_full_no_index, clk, rst, done && result.bank_full, result.assigned_index == 4'd0)
  `MCCT_ASSERT_IMP(a_one_kind, clk, rst, done, $countones({result.flag_was_set, result.bank_full, result.expiry_seen}) <= 1)

endmodule

bind multi_channel_countdown_timer_bank mcct_checker u_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done),
  .result(result)
);
